/* sv/wss_pkg.sv */
// Shared types and constants for the window sample statistics block.
// No dependencies; the other design files refer to it by scoped names, the testbench imports it.
`timescale 1ns / 1ps
`default_nettype none

package wss_pkg;

   // Default number of ring slots.
   localparam int RING_DEPTH = 256;

   // Fixed field widths of the request and response words.
   localparam int SAMPLE_W  = 16;
   localparam int TIME_W    = 32;
   localparam int NEXT_W    = 8;
   localparam int FILLED_W  = 9;
   localparam int TOTAL_W   = 31;
   localparam int WSIZE_W   = 9;

   // Total counter wraps from its maximum back to one.
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   // Window size after reset.
   localparam logic [WSIZE_W-1:0] WSIZE_RESET = WSIZE_W'(256);

   // Register port: byte address, one 32-bit register per word.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] CSR_WINDOW_SIZE = '0;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic        [TIME_W-1:0]   timestamp;
   } req_word_type;

   typedef struct packed {
      logic        [NEXT_W-1:0]   next_index;
      logic        [FILLED_W-1:0] filled_count;
      logic        [TOTAL_W-1:0]  total_count;
      logic signed [SAMPLE_W-1:0] max_value;
      logic        [TIME_W-1:0]   max_time;
      logic signed [SAMPLE_W-1:0] min_value;
      logic        [TIME_W-1:0]   min_time;
      logic signed [SAMPLE_W-1:0] mean_value;
   } rsp_word_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic capture;   // take the request word, read the ring slot
      logic update;    // write the ring, update sums, counters and peaks
      logic prep;      // load the divider from the window sum
      logic div_step;  // one restoring division step
      logic load_out;  // move the finished word into the output register
   } wss_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic out_free;  // output register empty or emptied this cycle
   } wss_stat_type;

endpackage

`default_nettype wire

/* sv/wss_ctrl.sv */
// Sequencer for the window sample statistics block: one word at a time.
// Depends on wss_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module wss_ctrl #(
   parameter int DIV_STEPS = wss_pkg::SAMPLE_W + $clog2(wss_pkg::RING_DEPTH + 1)
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wss_pkg::wss_stat_type  stat,
   output wss_pkg::wss_cmd_type   cmd
);

   localparam int STEP_W = $clog2(DIV_STEPS + 1);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_FETCH  = 5'b00010,
      S_PREP   = 5'b00100,
      S_DIVIDE = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            cmd.update = 1'b1;
            state_in   = S_PREP;
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            step_in  = STEP_W'(DIV_STEPS);
            state_in = S_DIVIDE;
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // hold until the output register can take the word
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

`default_nettype wire

/* sv/wss_datapath.sv */
// Datapath of the window sample statistics block: ring memory, window sum,
// counters, peaks, restoring divider, output register and the window size register.
// Depends on wss_pkg; driven by wss_ctrl through wss_cmd_type.
`timescale 1ns / 1ps
`default_nettype none

module wss_datapath #(
   parameter int RING_DEPTH = wss_pkg::RING_DEPTH
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wss_pkg::wss_cmd_type                   cmd,
   output wss_pkg::wss_stat_type                  stat,
   input  wss_pkg::req_word_type                  req_data,
   input  wire                                    psel,
   input  wire                                    penable,
   input  wire                                    pwrite,
   input  wire  [wss_pkg::CSR_ADDR_W-1:0]         paddr,
   input  wire  [wss_pkg::CSR_DATA_W-1:0]         pwdata,
   output logic [wss_pkg::CSR_DATA_W-1:0]         prdata,
   input  wire                                    pready,
   input  wire                                    rsp_ready,
   output logic                                   rsp_valid,
   output wss_pkg::rsp_word_type                  rsp_data
);

   localparam int SAMPLE_W = wss_pkg::SAMPLE_W;
   localparam int IDX_W    = $clog2(RING_DEPTH);
   localparam int CNT_W    = $clog2(RING_DEPTH + 1);
   localparam int SUM_W    = SAMPLE_W + CNT_W;

   // ring store, no reset: a slot's old value is used only after the window has filled it
   logic [SAMPLE_W-1:0] ring_mem_ff [RING_DEPTH];

   logic [wss_pkg::WSIZE_W-1:0]  wsize_ff, wsize_in;
   logic [IDX_W-1:0]             widx_ff, widx_in;
   logic [CNT_W-1:0]             fill_ff, fill_in;
   logic signed [SUM_W-1:0]      sum_ff, sum_in;
   logic [wss_pkg::TOTAL_W-1:0]  total_ff, total_in;
   logic signed [SAMPLE_W-1:0]   hi_ff, hi_in, lo_ff, lo_in;
   logic [wss_pkg::TIME_W-1:0]   hi_time_ff, hi_time_in, lo_time_ff, lo_time_in;
   logic                         seen_ff, seen_in;
   logic                         out_valid_ff, out_valid_in;

   // payload registers
   wss_pkg::req_word_type        word_ff;
   logic [IDX_W-1:0]             slot_ff;
   logic [SAMPLE_W-1:0]          old_ff;
   logic [SUM_W-1:0]             mag_ff;
   logic [CNT_W-1:0]             rem_ff;
   logic                         neg_ff;
   wss_pkg::rsp_word_type        out_ff;

   logic [CNT_W-1:0]             eff_size;
   logic [IDX_W-1:0]             slot_in;
   logic [CNT_W-1:0]             next_pos;
   logic                         full;
   logic signed [SUM_W-1:0]      samp_ext, old_ext;
   logic [CNT_W:0]               shifted, diff;
   logic                         qbit;
   logic [SUM_W-1:0]             mean_full;
   logic                         csr_wr;

   assign csr_wr = psel && penable && pwrite && pready &&
                   (paddr[wss_pkg::CSR_ADDR_W-1:2] == wss_pkg::CSR_WINDOW_SIZE);

   always_comb begin
      prdata = '0;
      if (paddr[wss_pkg::CSR_ADDR_W-1:2] == wss_pkg::CSR_WINDOW_SIZE) begin
         prdata = wss_pkg::CSR_DATA_W'(wsize_ff);
      end
   end

   // window size zero acts as one slot; above the ring depth it is clamped
   always_comb begin
      if (wsize_ff == '0) begin
         eff_size = CNT_W'(1);
      end else if (32'(wsize_ff) > 32'(RING_DEPTH)) begin
         eff_size = CNT_W'(RING_DEPTH);
      end else begin
         eff_size = CNT_W'(wsize_ff);
      end
   end

   assign slot_in  = (CNT_W'(widx_ff) >= eff_size) ? '0 : widx_ff;
   assign next_pos = CNT_W'(slot_ff) + CNT_W'(1);
   assign full     = (fill_ff >= eff_size);
   assign samp_ext = {{(SUM_W - SAMPLE_W){word_ff.sample[SAMPLE_W-1]}}, word_ff.sample};
   assign old_ext  = {{(SUM_W - SAMPLE_W){old_ff[SAMPLE_W-1]}}, old_ff};

   // restoring division step on the magnitude
   assign shifted = {rem_ff, mag_ff[SUM_W-1]};
   assign diff    = shifted - {1'b0, fill_ff};
   assign qbit    = !diff[CNT_W];

   assign mean_full = neg_ff ? (~mag_ff + SUM_W'(1)) : mag_ff;

   always_comb begin
      wsize_in   = wsize_ff;
      widx_in    = widx_ff;
      fill_in    = fill_ff;
      sum_in     = sum_ff;
      total_in   = total_ff;
      hi_in      = hi_ff;
      hi_time_in = hi_time_ff;
      lo_in      = lo_ff;
      lo_time_in = lo_time_ff;
      seen_in    = seen_ff;
      if (csr_wr) begin
         wsize_in = pwdata[wss_pkg::WSIZE_W-1:0];
         widx_in  = '0;
         fill_in  = '0;
         sum_in   = '0;
      end else if (cmd.update) begin
         if (full) begin
            fill_in = eff_size;
            sum_in  = sum_ff + samp_ext - old_ext;
         end else begin
            fill_in = fill_ff + CNT_W'(1);
            sum_in  = sum_ff + samp_ext;
         end
         widx_in  = (next_pos >= eff_size) ? '0 : IDX_W'(next_pos);
         total_in = (total_ff == wss_pkg::TOTAL_MAX) ?
                    wss_pkg::TOTAL_W'(1) : total_ff + wss_pkg::TOTAL_W'(1);
         // ties keep the earlier timestamp
         if (!seen_ff) begin
            hi_in      = word_ff.sample;
            hi_time_in = word_ff.timestamp;
            lo_in      = word_ff.sample;
            lo_time_in = word_ff.timestamp;
            seen_in    = 1'b1;
         end else if (word_ff.sample > hi_ff) begin
            hi_in      = word_ff.sample;
            hi_time_in = word_ff.timestamp;
         end else if (word_ff.sample < lo_ff) begin
            lo_in      = word_ff.sample;
            lo_time_in = word_ff.timestamp;
         end
      end
   end

   assign stat.out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wsize_ff     <= wss_pkg::WSIZE_RESET;
         widx_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         total_ff     <= '0;
         hi_ff        <= '0;
         hi_time_ff   <= '0;
         lo_ff        <= '0;
         lo_time_ff   <= '0;
         seen_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         wsize_ff     <= wsize_in;
         widx_ff      <= widx_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         total_ff     <= total_in;
         hi_ff        <= hi_in;
         hi_time_ff   <= hi_time_in;
         lo_ff        <= lo_in;
         lo_time_ff   <= lo_time_in;
         seen_ff      <= seen_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // ring memory: one read port at capture, one write port at update
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         old_ff <= ring_mem_ff[slot_in];
      end
      if (cmd.update) begin
         ring_mem_ff[slot_ff] <= word_ff.sample;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         word_ff <= req_data;
         slot_ff <= slot_in;
      end
      if (cmd.prep) begin
         neg_ff <= sum_ff[SUM_W-1];
         mag_ff <= sum_ff[SUM_W-1] ? (~sum_ff + SUM_W'(1)) : sum_ff;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         mag_ff <= {mag_ff[SUM_W-2:0], qbit};
         rem_ff <= qbit ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      end
      if (cmd.load_out) begin
         out_ff.next_index   <= wss_pkg::NEXT_W'(widx_ff);
         out_ff.filled_count <= wss_pkg::FILLED_W'(fill_ff);
         out_ff.total_count  <= total_ff;
         out_ff.max_value    <= hi_ff;
         out_ff.max_time     <= hi_time_ff;
         out_ff.min_value    <= lo_ff;
         out_ff.min_time     <= lo_time_ff;
         out_ff.mean_value   <= mean_full[SAMPLE_W-1:0];
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

/* sv/window_sample_statistics_core.sv */
// Top level of the window sample statistics block: sequencer plus datapath.
// Depends on wss_pkg, wss_ctrl and wss_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Each request word carries one signed Q7.8 sample and a 32-bit timestamp.
// The sample goes into a ring of window_size slots (0 acts as 1, anything
// above RING_DEPTH acts as RING_DEPTH), and every request produces exactly
// one response word: the next ring slot, the number of stored samples, a
// total counter that wraps from 2^31-1 to 1, the all-time maximum and
// minimum with their timestamps (the first sample sets both; a tie keeps
// the earlier timestamp), and the window mean truncated toward zero.
// Words are handled one at a time. A request is taken in the idle state,
// which also reads its ring slot; the fetch state then updates sum,
// counters and peaks, the prep state loads the divider, the restoring
// divider retires one quotient bit per cycle over the 16 +
// clog2(RING_DEPTH+1) bits of the window sum, and the finish state hands
// the word to the output register once that register is free. The output
// register lets the next request in while a finished response still waits
// for rsp_ready. Writing window_size (byte address 0) empties the window;
// max, min and the total are kept.
// Write it only while no request is in flight.

module window_sample_statistics_core #(
   parameter int RING_DEPTH = wss_pkg::RING_DEPTH
) (
   input  wire                                clock,
   input  wire                                reset,
   // request channel
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wss_pkg::req_word_type              req_data,
   // response channel
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output wss_pkg::rsp_word_type              rsp_data,
   // register port
   input  wire                                psel,
   input  wire                                penable,
   input  wire                                pwrite,
   input  wire  [wss_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire  [wss_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [wss_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);

   // one quotient bit per cycle over the full width of the window sum
   localparam int DIV_STEPS = wss_pkg::SAMPLE_W + $clog2(RING_DEPTH + 1);

   wss_pkg::wss_cmd_type   cmd;
   wss_pkg::wss_stat_type  stat;

   // register writes always complete in the access cycle
   assign pready = 1'b1;

   wss_ctrl #(
      .DIV_STEPS (DIV_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   wss_datapath #(
      .RING_DEPTH (RING_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* sv/wss_checker.sv */
// Port-level checks for window_sample_statistics_core, attached by bind.
// Depends on wss_pkg and the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module wss_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    req_valid,
   input wire                    req_ready,
   input wire                    rsp_valid,
   input wire                    rsp_ready,
   input wss_pkg::rsp_word_type  rsp_data
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   // one word at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a word is in flight");

   // a response always covers at least one sample and ordered peaks
   a_peaks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.filled_count != 0 &&
                    rsp_data.max_value >= rsp_data.min_value)
      else $error("response fill count or peak order wrong");

   // the window mean lies between the all-time extremes
   a_mean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.mean_value <= rsp_data.max_value &&
                    rsp_data.mean_value >= rsp_data.min_value)
      else $error("mean outside peak range");

   // nothing pending right out of reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind window_sample_statistics_core wss_checker u_wss_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

/* sim/window_sample_statistics_core_tb.sv */
// Self-checking testbench for window_sample_statistics_core: a directed table, then random
// phases over several window sizes and idle patterns, checked by an in-bench predictor.
// Depends on wss_pkg and window_sample_statistics_core.
`timescale 1ns / 1ps

module window_sample_statistics_core_tb;

   import wss_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int RANDOM_PHASES  = 13;
   localparam logic [CSR_ADDR_W-1:0] WSIZE_ADDR = {CSR_WINDOW_SIZE, 2'b00};

   typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

   typedef struct {
      row_kind_e          kind;
      logic [WSIZE_W-1:0] wsize;
      logic [15:0]        sample;
      logic [31:0]        stamp;
      bit                 known;
      rsp_word_type       want;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_word_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_word_type          rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Idle percentages of the current phase.
   int unsigned send_gap_pct = 0;
   int unsigned recv_stall_pct = 0;

   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles = 0;

   // Expected statistics words, oldest first.
   rsp_word_type pending_stats [$];

   // Predictor state.
   logic [WSIZE_W-1:0]  win_size = WSIZE_RESET;
   logic signed [15:0]  ring_copy [RING_DEPTH];
   int unsigned         wr_slot = 0;
   int unsigned         held = 0;
   longint              run_sum = 0;
   logic [TOTAL_W-1:0]  total_seen = '0;
   logic signed [15:0]  peak_hi = '0;
   logic [31:0]         peak_hi_at = '0;
   logic signed [15:0]  peak_lo = '0;
   logic [31:0]         peak_lo_at = '0;
   bit                  have_peak = 1'b0;

   // Directed table. Rows with a typed-in word are checked against it; the rest
   // go through the predictor.
   stim_row_t directed [25] = '{
      // first sample sets max and min, extremes of both fields
      '{ROW_ITEM, '0, 16'h7FFF, 32'hFFFF_FFFF, 1'b1,
        '{8'd1, 9'd1, 31'd1, 16'sh7FFF, 32'hFFFF_FFFF, 16'sh7FFF, 32'hFFFF_FFFF,
          16'sh7FFF}},
      // -1/2 truncates to zero
      '{ROW_ITEM, '0, 16'h8000, 32'h0000_0000, 1'b1,
        '{8'd2, 9'd2, 31'd2, 16'sh7FFF, 32'hFFFF_FFFF, -16'sd32768, 32'h0, 16'sh0}},
      // ties keep the earlier timestamps
      '{ROW_ITEM, '0, 16'h7FFF, 32'h0000_0005, 1'b0, '0},
      '{ROW_ITEM, '0, 16'h8000, 32'h0000_0006, 1'b0, '0},
      // size zero acts as one slot
      '{ROW_CFG,  9'd0, '0, '0, 1'b0, '0},
      '{ROW_ITEM, '0, 16'h0100, 32'h1234_5678, 1'b1,
        '{8'd0, 9'd1, 31'd5, 16'sh7FFF, 32'hFFFF_FFFF, -16'sd32768, 32'h0, 16'sh0100}},
      '{ROW_ITEM, '0, 16'hFF00, 32'hAAAA_AAAA, 1'b0, '0},
      '{ROW_CFG,  9'd1, '0, '0, 1'b0, '0},
      '{ROW_ITEM, '0, 16'h5555, 32'h5555_5555, 1'b0, '0},
      '{ROW_ITEM, '0, 16'hAAAA, 32'hAAAA_AAAA, 1'b0, '0},
      // small window, negative means truncate toward zero
      '{ROW_CFG,  9'd3, '0, '0, 1'b0, '0},
      '{ROW_ITEM, '0, 16'hFFFF, 32'h0000_0001, 1'b0, '0},
      '{ROW_ITEM, '0, 16'hFFFE, 32'h0000_0002, 1'b0, '0},
      '{ROW_ITEM, '0, 16'h0001, 32'h0000_0003, 1'b0, '0},
      '{ROW_ITEM, '0, 16'h0003, 32'h0000_0004, 1'b0, '0},
      '{ROW_ITEM, '0, 16'hFFF9, 32'h0000_0005, 1'b0, '0},
      // size above the ring depth acts as the full ring
      '{ROW_CFG,  9'd511, '0, '0, 1'b0, '0},
      '{ROW_ITEM, '0, 16'h0000, 32'h0000_0000, 1'b0, '0},
      '{ROW_ITEM, '0, 16'h7FFF, 32'hFFFF_FFFF, 1'b0, '0},
      '{ROW_ITEM, '0, 16'h8000, 32'h0000_0000, 1'b0, '0},
      '{ROW_CFG,  9'd2, '0, '0, 1'b0, '0},
      '{ROW_ITEM, '0, 16'h0080, 32'h8000_0000, 1'b0, '0},
      '{ROW_ITEM, '0, 16'hFF80, 32'h7FFF_FFFF, 1'b0, '0},
      '{ROW_ITEM, '0, 16'h0001, 32'hFFFF_FFFF, 1'b0, '0},
      '{ROW_CFG,  9'd256, '0, '0, 1'b0, '0}
   };

   window_sample_statistics_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Advance the predictor by one sample and return the statistics word it implies.
   function automatic void advance_window_stats(input req_word_type w, output rsp_word_type r);
      int unsigned        span;
      int unsigned        slot;
      logic signed [15:0] s;
      longint             mean;
      s = w.sample;
      span = (win_size == 0) ? 1 : ((win_size > RING_DEPTH) ? RING_DEPTH : win_size);
      slot = (wr_slot >= span) ? 0 : wr_slot;
      if (held >= span) begin
         held = span;
         run_sum -= longint'(ring_copy[slot]);
      end else begin
         held++;
      end
      ring_copy[slot] = s;
      run_sum += longint'(s);
      if (!have_peak) begin
         peak_hi = s;
         peak_hi_at = w.timestamp;
         peak_lo = s;
         peak_lo_at = w.timestamp;
         have_peak = 1'b1;
      end else if (s > peak_hi) begin
         peak_hi = s;
         peak_hi_at = w.timestamp;
      end else if (s < peak_lo) begin
         peak_lo = s;
         peak_lo_at = w.timestamp;
      end
      wr_slot = (slot + 1 >= span) ? 0 : slot + 1;
      total_seen = (total_seen == TOTAL_MAX) ? TOTAL_W'(1) : total_seen + 1'b1;
      mean = run_sum / longint'(held);
      r.next_index   = wr_slot[NEXT_W-1:0];
      r.filled_count = held[FILLED_W-1:0];
      r.total_count  = total_seen;
      r.max_value    = peak_hi;
      r.max_time     = peak_hi_at;
      r.min_value    = peak_lo;
      r.min_time     = peak_lo_at;
      r.mean_value   = mean[15:0];
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Offer one word, hold it until taken, then record what it should produce.
   // A typed-in word replaces the prediction; the predictor still advances.
   task automatic push_sample(input req_word_type w, input bit known, input rsp_word_type want);
      rsp_word_type predicted;
      while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      advance_window_stats(w, predicted);
      pending_stats.push_back(known ? want : predicted);
   endtask

   // Drain, then write the window size and read it back.
   task automatic set_window_size(input logic [WSIZE_W-1:0] size);
      req_valid <= 1'b0;
      while (pending_stats.size() != 0) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= WSIZE_ADDR;
      pwdata  <= CSR_DATA_W'(size);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      // write lands here: the window empties, peaks and total stay
      win_size = size;
      wr_slot  = 0;
      held     = 0;
      run_sum  = 0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      check_field("window_size readback", 32'(size), 32'(prdata[WSIZE_W-1:0]));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Take statistics words and compare each with the oldest expectation.
   always @(posedge clock) begin : stats_sink
      rsp_word_type want;
      if (rsp_valid && rsp_ready) begin
         if (pending_stats.size() == 0) begin
            $display("%0t ns: unexpected word, expected none, got %h", $time, rsp_data);
            mismatch_count++;
         end else begin
            want = pending_stats.pop_front();
            check_field("next_index", 32'(want.next_index), 32'(rsp_data.next_index));
            check_field("filled_count", 32'(want.filled_count), 32'(rsp_data.filled_count));
            check_field("total_count", 32'(want.total_count), 32'(rsp_data.total_count));
            check_field("max_value", 32'(want.max_value), 32'(rsp_data.max_value));
            check_field("max_time", want.max_time, rsp_data.max_time);
            check_field("min_value", 32'(want.min_value), 32'(rsp_data.min_value));
            check_field("min_time", want.min_time, rsp_data.min_time);
            check_field("mean_value", 32'(want.mean_value), 32'(rsp_data.mean_value));
         end
      end
      rsp_ready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Drop the run if nothing moves on any port for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      req_word_type       w;
      logic [WSIZE_W-1:0] size;
      int unsigned        count;
      for (int i = 0; i < RING_DEPTH; i++) ring_copy[i] = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table, no idling.
      foreach (directed[i]) begin
         if (directed[i].kind == ROW_CFG) begin
            set_window_size(directed[i].wsize);
         end else begin
            w.sample    = directed[i].sample;
            w.timestamp = directed[i].stamp;
            push_sample(w, directed[i].known, directed[i].want);
         end
      end

      // Random phases: each picks a window size and an idle pattern. The first
      // two run long enough to wrap a full ring.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin size = 9'd256; count = 300; end
            1: begin size = 9'd511; count = 270; end
            2: begin size = 9'd1;   count = $urandom_range(40, 90); end
            3: begin size = 9'd0;   count = $urandom_range(40, 90); end
            4: begin size = 9'd255; count = $urandom_range(40, 90); end
            5: begin size = 9'd257; count = $urandom_range(40, 90); end
            default: begin
               size  = WSIZE_W'($urandom_range(2, 40));
               count = $urandom_range(40, 90);
            end
         endcase
         set_window_size(size);
         case (p % 4)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 58; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 58; end
            default: begin send_gap_pct = 19; recv_stall_pct = 19; end
         endcase
         for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 15))
               0: w.sample = 16'sh7FFF;
               1: w.sample = -16'sd32768;
               2: w.sample = peak_hi;   // tie with the maximum
               3: w.sample = peak_lo;   // tie with the minimum
               4: w.sample = 16'($signed($urandom_range(0, 15)) - 8);
               default: w.sample = 16'($urandom());
            endcase
            w.timestamp = $urandom();
            push_sample(w, 1'b0, '0);
         end
      end

      // Wait out the tail.
      req_valid <= 1'b0;
      send_gap_pct = 0;
      recv_stall_pct = 0;
      while (pending_stats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
